/* hw/rtl/lps_pkg.sv */
// Shared types, constants and field layout for the latency percentile selector.
package lps_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int NUM_PCT_DEF = 3;

  localparam int SAMPLE_W = 32;
  localparam int PCT_W = 7;
  localparam int NUM_CFG_REGS = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = PCT_W;

  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [SAMPLE_W-1:0] SIGN_BIAS = 32'h8000_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PERCENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_PERCENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_PERCENT = 2'd2;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_INDEX,
    S_SCAN,
    S_DECIDE,
    S_EMIT
  } lps_state_t;

  // Reset value of percentile register i; entries past the register list report the maximum.
  function automatic logic [PCT_W-1:0] pct_reset_value(input int i);
    logic [PCT_W-1:0] v;
    case (i)
      0: v = 7'd90;
      1: v = 7'd95;
      2: v = 7'd99;
      default: v = PCT_FULL;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/lps_rank_index.sv */
// Rank index unit: floor(count * pct / 100), clamped to the last kept sample.
module lps_rank_index #(
  parameter int DEPTH = lps_pkg::DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [CW-1:0]           count,
  input  logic [lps_pkg::PCT_W-1:0] pct,
  output logic                    done,
  output logic [CW-1:0]           idx
);
  import lps_pkg::*;

  localparam int XW = CW + PCT_W;
  localparam int RECIP_W = 24;
  localparam int RECIP_SHIFT = 30;
  // floor(2^30 / 100); the estimate below is low by at most one for any product under 2^30.
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 100);
  localparam int PW = XW + RECIP_W;

  // count and pct are held steady by the caller from start until done.
  logic            v1_r, v2_r, v3_r;
  logic [XW-1:0]   prod_r;
  logic [CW-1:0]   q0_r;
  logic [PW-1:0]   recip_prod;
  logic [XW-1:0]   rem;
  logic [CW-1:0]   q_fix;
  logic [CW-1:0]   last_idx;
  logic [CW-1:0]   idx_nxt;

  assign recip_prod = PW'(prod_r) * PW'(RECIP);
  assign rem = prod_r - XW'(q0_r) * XW'(100);
  assign q_fix = (rem >= XW'(100)) ? q0_r + CW'(1) : q0_r;
  assign last_idx = count - CW'(1);

  always_comb begin
    if (pct >= PCT_FULL || q_fix >= count) begin
      idx_nxt = last_idx;
    end else begin
      idx_nxt = q_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= XW'(count) * XW'(pct);
    q0_r <= recip_prod[RECIP_SHIFT +: CW];
    if (v2_r) begin
      idx <= idx_nxt;
    end
  end

  assign done = v3_r;

endmodule

/* hw/rtl/latency_percentile_select.sv */
// Top level of the latency percentile selector: sample store, radix selection and result port.
//
// Samples are written into a store with one write port and one registered read port at one
// transaction per cycle; up to DEPTH are kept and later ones only raise the overflow flag. The
// transaction with in_tlast set also carries a sample, after which in_tready drops and the block
// reports NUM_PERCENTILES results. Each result is found by a bitwise radix selection: 32 passes
// over the kept samples, each pass streaming the store once through its registered read port
// and then settling one bit. A zero percentage skips the search.
// in_tready returns as soon as the last result sits in the output register.
module latency_percentile_select #(
  parameter int DEPTH = lps_pkg::DEPTH_DEF,
  parameter int NUM_PERCENTILES = lps_pkg::NUM_PCT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lps_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] sample
  input  logic                             in_tlast,   // is_final
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lps_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [6:0] percent, [38:7] rank_value
  output logic [lps_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] never_flag, [1] overflow_flag
  output logic                             out_tlast   // last_of_run
);
  import lps_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int KW = (NUM_PERCENTILES > 1) ? $clog2(NUM_PERCENTILES) : 1;

  lps_state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  logic [PCT_W-1:0] pct_r [NUM_PERCENTILES];
  logic [CW-1:0]    count_r;
  logic             dropped_r;
  logic [KW-1:0]    k_r;

  logic [CW-1:0]       issue_addr_r;
  logic                rd_vld_r;
  logic [CW-1:0]       hit_r;
  logic [CW-1:0]       rank_r;
  logic [SAMPLE_W-1:0] prefix_r;
  logic [SAMPLE_W-1:0] mask_r;
  logic [SAMPLE_W-1:0] bitsel_r;
  logic [SAMPLE_W-1:0] res_val_r;
  logic                res_never_r;

  logic                out_valid_r;
  logic [PCT_W-1:0]    out_pct_r;
  logic [SAMPLE_W-1:0] out_val_r;
  logic                out_never_r;
  logic                out_ovf_r;
  logic                out_last_r;

  logic                in_acc;
  logic                has_room;
  logic                idx_start;
  logic                idx_done;
  logic [CW-1:0]       idx_val;
  logic                issuing;
  logic                load_out;
  logic                last_k;
  logic [PCT_W-1:0]    pct_cur;
  logic [PCT_W-1:0]    pct_report;
  logic [SAMPLE_W-1:0] biased;
  logic                hit;
  logic                take_one;
  logic [SAMPLE_W-1:0] prefix_dec;

  assign in_acc = in_tvalid && in_tready;
  assign has_room = (count_r < CW'(DEPTH));
  assign pct_cur = pct_r[k_r];
  assign last_k = (k_r == KW'(NUM_PERCENTILES - 1));
  assign issuing = (issue_addr_r < count_r);

  always_comb begin
    if (pct_cur >= PCT_FULL) begin
      pct_report = PCT_FULL;
    end else begin
      pct_report = pct_cur;
    end
  end

  // A sample counts toward the current bit when its settled upper bits match and this bit is 0.
  assign biased = rd_data_r ^ SIGN_BIAS;
  assign hit = (((biased ^ prefix_r) & mask_r) == '0) && ((biased & bitsel_r) == '0);
  assign take_one = (rank_r >= hit_r);
  assign prefix_dec = take_one ? (prefix_r | bitsel_r) : prefix_r;

  lps_rank_index #(
    .DEPTH(DEPTH)
  ) u_rank_index (
    .clk   (clk),
    .rst_n (rst_n),
    .start (idx_start),
    .count (count_r),
    .pct   (pct_cur),
    .done  (idx_done),
    .idx   (idx_val)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_tlast) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (pct_cur == '0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_INDEX;
        end
      end
      S_INDEX: begin
        if (idx_done) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issuing && !rd_vld_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (bitsel_r[0]) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          state_nxt = last_k ? S_LOAD : S_START;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready = 1'b0;
    idx_start = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_LOAD:  in_tready = 1'b1;
      S_START: idx_start = (pct_cur != '0);
      S_EMIT:  load_out = !out_valid_r || out_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sample store: written while loading, streamed while searching.
  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      mem[count_r[AW-1:0]] <= in_tdata[SAMPLE_W-1:0];
    end
    rd_data_r <= mem[issue_addr_r[AW-1:0]];
  end

  for (genvar i = 0; i < NUM_PERCENTILES; i++) begin : g_pct
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pct_r[i] <= pct_reset_value(i);
      end else if (cfg_we && i < NUM_CFG_REGS && cfg_index == CFG_IDX_W'(i)) begin
        pct_r[i] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dropped_r <= 1'b0;
      k_r <= '0;
      rd_vld_r <= 1'b0;
      issue_addr_r <= '0;
    end else begin
      rd_vld_r <= (state_r == S_SCAN) && issuing;
      if (in_acc) begin
        if (has_room) begin
          count_r <= count_r + CW'(1);
        end else begin
          dropped_r <= 1'b1;
        end
        k_r <= '0;
      end
      if ((state_r == S_SCAN) && issuing) begin
        issue_addr_r <= issue_addr_r + CW'(1);
      end else if (state_r == S_INDEX || state_r == S_DECIDE) begin
        issue_addr_r <= '0;
      end
      if (load_out) begin
        if (last_k) begin
          count_r <= '0;
          dropped_r <= 1'b0;
        end else begin
          k_r <= k_r + KW'(1);
        end
      end
    end
  end

  // Radix search datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      S_START: begin
        prefix_r <= '0;
        mask_r <= '0;
        bitsel_r <= SIGN_BIAS;
        res_val_r <= '0;
        res_never_r <= (pct_cur == '0);
      end
      S_INDEX: begin
        rank_r <= idx_val;
        hit_r <= '0;
      end
      S_SCAN: begin
        if (rd_vld_r && hit) begin
          hit_r <= hit_r + CW'(1);
        end
      end
      S_DECIDE: begin
        prefix_r <= prefix_dec;
        if (take_one) begin
          rank_r <= rank_r - hit_r;
        end
        hit_r <= '0;
        mask_r <= {1'b1, mask_r[SAMPLE_W-1:1]};
        bitsel_r <= {1'b0, bitsel_r[SAMPLE_W-1:1]};
        if (bitsel_r[0]) begin
          res_val_r <= prefix_dec ^ SIGN_BIAS;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pct_r <= pct_report;
      out_val_r <= res_val_r;
      out_never_r <= res_never_r;
      out_ovf_r <= dropped_r;
      out_last_r <= last_k;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, out_val_r, out_pct_r};
  assign out_tuser = {out_ovf_r, out_never_r};
  assign out_tlast = out_last_r;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the latency percentile selector: directed sets, overflow, random sets.
`timescale 1ns / 1ps

module testbench;

  localparam int STORE_DEPTH = 1024;
  localparam int NUM_RANKS = 3;
  localparam int MAX_GAP = 17;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 100;
  localparam int MIN_RANDOM_SETS = 14;
  localparam int MAX_REPORTS = 10;

  localparam int SAMPLE_MIN = 32'h8000_0000;
  localparam int SAMPLE_MAX = 32'h7FFF_FFFF;

  // Index 3 is decoded by the port but maps to no register.
  localparam logic [lps_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [lps_pkg::PCT_W-1:0]       percent;
    logic signed [lps_pkg::SAMPLE_W-1:0] rank_value;
    logic                            never_flag;
    logic                            overflow_flag;
    logic                            last_of_run;
  } rank_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lps_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // [31:0] sample
  logic in_tlast = 1'b0;                            // is_final
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lps_pkg::OUT_TDATA_W-1:0] out_tdata;      // [6:0] percent, [38:7] rank_value
  logic [lps_pkg::OUT_TUSER_W-1:0] out_tuser;      // [0] never_flag, [1] overflow_flag
  logic out_tlast;                                  // last_of_run

  // Model of the block's state and registers.
  int kept_samples[$];
  bit dropped_model;
  logic [lps_pkg::PCT_W-1:0] pct_model [lps_pkg::NUM_CFG_REGS];
  rank_result_t pending_ranks[$];

  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  bit hold_off_armed = 1'b0;
  int items_sent = 0;
  int sets_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int stalled_cycles = 0;

  latency_percentile_select #(
    .DEPTH(STORE_DEPTH),
    .NUM_PERCENTILES(NUM_RANKS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stores one accepted sample and, on the final one, works out the ranked results.
  task automatic record_sample(input int value, input bit fin);
    int sorted_vals[$];
    int key;
    int j;
    longint pos;
    logic [lps_pkg::PCT_W-1:0] p;
    rank_result_t r;
    if (kept_samples.size() < STORE_DEPTH) begin
      kept_samples.insert(kept_samples.size(), value);
    end else begin
      dropped_model = 1'b1;
    end
    if (fin) begin
      sorted_vals = kept_samples;
      for (int i = 1; i < sorted_vals.size(); i++) begin
        key = sorted_vals[i];
        j = i;
        while (j > 0 && sorted_vals[j-1] > key) begin
          sorted_vals[j] = sorted_vals[j-1];
          j--;
        end
        sorted_vals[j] = key;
      end
      for (int k = 0; k < NUM_RANKS; k++) begin
        p = (k < lps_pkg::NUM_CFG_REGS) ? pct_model[k] : lps_pkg::PCT_FULL;
        r.never_flag = 1'b0;
        r.rank_value = '0;
        if (p == 0) begin
          r.percent = '0;
          r.never_flag = 1'b1;
        end else if (p >= lps_pkg::PCT_FULL) begin
          r.percent = lps_pkg::PCT_FULL;
          r.rank_value = sorted_vals[sorted_vals.size()-1];
        end else begin
          pos = (longint'(sorted_vals.size()) * longint'(p)) / 100;
          if (pos >= sorted_vals.size()) pos = sorted_vals.size() - 1;
          r.percent = p;
          r.rank_value = sorted_vals[pos];
        end
        r.overflow_flag = dropped_model;
        r.last_of_run = (k == NUM_RANKS - 1);
        pending_ranks.insert(pending_ranks.size(), r);
      end
      kept_samples.delete();
      dropped_model = 1'b0;
      sets_sent++;
    end
  endtask

  task automatic send_sample(input int value, input bit fin);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    record_sample(value, fin);
  endtask

  // Lowers the input and waits until every result is out and the block has settled.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [lps_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lps_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx < lps_pkg::NUM_CFG_REGS) pct_model[idx] = value;
  endtask

  task automatic write_percents(input int first, input int second, input int third);
    write_register(lps_pkg::REG_FIRST_PERCENT, first[lps_pkg::PCT_W-1:0]);
    write_register(lps_pkg::REG_SECOND_PERCENT, second[lps_pkg::PCT_W-1:0]);
    write_register(lps_pkg::REG_THIRD_PERCENT, third[lps_pkg::PCT_W-1:0]);
  endtask

  task automatic check_result();
    rank_result_t got;
    rank_result_t want;
    got.percent = out_tdata[6:0];
    got.rank_value = out_tdata[38:7];
    got.never_flag = out_tuser[0];
    got.overflow_flag = out_tuser[1];
    got.last_of_run = out_tlast;
    results_checked++;
    if (pending_ranks.size() == 0) begin
      if (mismatch_count < MAX_REPORTS)
        $display("ERROR: unexpected result pct=%0d value=%0d never=%0b ovf=%0b last=%0b",
                 got.percent, got.rank_value, got.never_flag, got.overflow_flag,
                 got.last_of_run);
      mismatch_count++;
    end else begin
      want = pending_ranks.pop_front();
      if (got.percent !== want.percent || got.rank_value !== want.rank_value ||
          got.never_flag !== want.never_flag || got.overflow_flag !== want.overflow_flag ||
          got.last_of_run !== want.last_of_run) begin
        if (mismatch_count < MAX_REPORTS)
          $display("ERROR: result %0d expected pct=%0d value=%0d never=%0b ovf=%0b last=%0b, %s",
                   results_checked, want.percent, want.rank_value, want.never_flag,
                   want.overflow_flag, want.last_of_run,
                   $sformatf("got pct=%0d value=%0d never=%0b ovf=%0b last=%0b",
                             got.percent, got.rank_value, got.never_flag,
                             got.overflow_flag, got.last_of_run));
        mismatch_count++;
      end
    end
  endtask

  // Result sink: random stalls per transaction, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = stall_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result();
    end
  end

  initial begin : watchdog
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Reset percentages, a one-sample set and a set with the extreme sample values.
  task automatic test_default_percents();
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(-1000, 1'b1);
    drain_results();
  endtask

  // Zero gives no value, 100 and above give the largest, an unmapped index is ignored.
  task automatic test_percent_extremes();
    write_percents(0, 100, 127);
    send_sample(5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(1, 1'b1);
    drain_results();
    write_percents(1, 50, 99);
    write_register(REG_UNUSED, '0);
    send_sample(40, 1'b0);
    send_sample(10, 1'b0);
    send_sample(30, 1'b0);
    send_sample(20, 1'b1);
    drain_results();
  endtask

  // One sample past capacity is dropped; the flag must clear for the following set.
  task automatic test_store_overflow();
    idle_on = 1'b0;
    write_percents(0, 50, 100);
    for (int i = 0; i < STORE_DEPTH; i++) send_sample(int'($urandom), 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    idle_on = 1'b1;
    send_sample(3, 1'b0);
    send_sample(-3, 1'b0);
    send_sample(0, 1'b1);
    drain_results();
  endtask

  // The sink holds off while the next set is already offered, so the input must stall.
  task automatic test_output_hold_off();
    write_percents(90, 95, 99);
    hold_off_armed = 1'b1;
    idle_on = 1'b0;
    send_sample(100, 1'b0);
    send_sample(200, 1'b0);
    send_sample(300, 1'b1);
    send_sample(-9, 1'b0);
    send_sample(9, 1'b1);
    idle_on = 1'b1;
    drain_results();
  endtask

  task automatic test_random_sets();
    int start_items;
    int sets_done;
    int set_len;
    int mode;
    int value;
    int pick [lps_pkg::NUM_CFG_REGS];
    start_items = items_sent;
    sets_done = 0;
    while (items_sent - start_items < RANDOM_ITEMS || sets_done < MIN_RANDOM_SETS) begin
      if (sets_done % 3 == 2) begin
        drain_results();
        for (int r = 0; r < lps_pkg::NUM_CFG_REGS; r++) begin
          case ($urandom_range(0, 4))
            0: pick[r] = 0;
            1: pick[r] = 100;
            2: pick[r] = 127;
            3: pick[r] = $urandom_range(1, 99);
            default: pick[r] = $urandom_range(0, 127);
          endcase
        end
        write_percents(pick[0], pick[1], pick[2]);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < set_len; i++) begin
        // Narrow ranges give many equal samples; the mixed mode brings in the extremes.
        if (mode == 1) begin
          value = int'($urandom_range(0, 16)) - 8;
        end else if (mode == 2 && $urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 3))
            0: value = SAMPLE_MIN;
            1: value = SAMPLE_MAX;
            2: value = 0;
            default: value = -1;
          endcase
        end else begin
          value = int'($urandom);
        end
        send_sample(value, i == set_len - 1);
      end
      sets_done++;
    end
    idle_on = 1'b1;
    stall_on = 1'b1;
    drain_results();
  endtask

  initial begin : stimulus
    dropped_model = 1'b0;
    for (int i = 0; i < lps_pkg::NUM_CFG_REGS; i++) pct_model[i] = lps_pkg::pct_reset_value(i);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_percents();
    test_percent_extremes();
    test_store_overflow();
    test_output_hold_off();
    test_random_sets();

    $display("Summary: %0d samples in %0d sets, %0d results checked, %0d mismatches.",
             items_sent, sets_sent, results_checked, mismatch_count);
    $display("Summary: included edge percentages, a store overflow and a long output hold-off.");
    if (mismatch_count == 0 && pending_ranks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* latency_percentile_select.f */
hw/rtl/lps_pkg.sv
hw/rtl/lps_rank_index.sv
hw/rtl/latency_percentile_select.sv
bench/testbench.sv
